// ===== design/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and operation codes for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_PUSH      = 2'd0;
    localparam op_t OP_POP_BACK  = 2'd1;
    localparam op_t OP_POP_FRONT = 2'd2;

endpackage

// ===== design/ring_buffer_deque_top.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// Double-ended queue in a ring of memory slots: push back, pop back, pop front.
// ----------------------------------------------------------------------------
// Each input item is one operation: push at the back, pop from the back or pop
// from the front. A push into a full ring, a pop from an empty ring and the
// unused op code are rejected and leave the state unchanged. Every item yields
// one result item: accepted flag, popped element (zero unless an accepted pop)
// and the empty flag, full flag and count after the operation. One item is
// taken per cycle while the result path is not stalled; its result goes
// through the registered read port of the slot memory and then the output
// register. A stalled result holds the input off.
// The slot memory has no reset; indices and count reset to zero. Writing the
// capacity register (1..DEPTH; 0 acts as 1, larger values act as DEPTH) also
// empties the queue, and is only to be done with no items in flight.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top #(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32,
    localparam int IDX_W        = $clog2(DEPTH),
    localparam int CAP_W        = $clog2(DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  rbd_pkg::op_t             s_op,
    input  logic [ELEMENT_WIDTH-1:0] s_item_value,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_accepted,
    output logic [ELEMENT_WIDTH-1:0] m_item_out,
    output logic                     m_is_empty,
    output logic                     m_is_full,
    output logic [CAP_W-1:0]         m_count
);
    import rbd_pkg::*;

    typedef struct packed {
        logic             accepted;
        logic             pop;
        logic             is_empty;
        logic             is_full;
        logic [CAP_W-1:0] count;
    } pipe_t;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W:0] inc;
        inc = {{(CAP_W + 1 - IDX_W){1'b0}}, idx} + (CAP_W + 1)'(1);
        return (inc >= {1'b0, cap}) ? '0 : inc[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] top;
        top = cap - CAP_W'(1);
        return (idx == '0) ? top[IDX_W-1:0] : idx - IDX_W'(1);
    endfunction

    logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

    logic [CAP_W-1:0]         cap_reg;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [IDX_W-1:0]         back_reg, back_next;
    logic [CAP_W-1:0]         count_reg, count_next;
    logic                     p_valid_reg;
    pipe_t                    p_reg, p_next;
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;
    logic                     m_valid_reg;
    pipe_t                    m_reg;
    logic [ELEMENT_WIDTH-1:0] m_item_reg, m_item_next;

    logic [CAP_W-1:0] cap_live;
    logic             in_fire;
    logic             out_load;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    assign cap_live = (cap_reg == '0)           ? CAP_W'(1)     :
                      (cap_reg > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_reg;

    assign out_load  = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = (!p_valid_reg || out_load) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;

    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        p_next     = '0;
        case (s_op)
            OP_PUSH: begin
                if (count_reg < cap_live) begin
                    wr_en           = in_fire;
                    back_next       = step_up(back_reg, cap_live);
                    count_next      = count_reg + CAP_W'(1);
                    p_next.accepted = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (count_reg != '0) begin
                    back_next       = step_down(back_reg, cap_live);
                    rd_addr         = back_next;
                    rd_en           = in_fire;
                    count_next      = count_reg - CAP_W'(1);
                    p_next.accepted = 1'b1;
                    p_next.pop      = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (count_reg != '0) begin
                    front_next      = step_up(front_reg, cap_live);
                    rd_en           = in_fire;
                    count_next      = count_reg - CAP_W'(1);
                    p_next.accepted = 1'b1;
                    p_next.pop      = 1'b1;
                end
            end
            default: begin
            end
        endcase
        p_next.count    = count_next;
        p_next.is_empty = (count_next == '0);
        p_next.is_full  = (count_next >= cap_live);
    end

    assign m_item_next = p_reg.pop ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[back_reg] <= s_item_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_W'(DEPTH);
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg   <= cfg_data;
                front_reg <= '0;
                back_reg  <= '0;
                count_reg <= '0;
            end else if (in_fire) begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
            if (in_fire) begin
                p_valid_reg <= 1'b1;
            end else if (out_load) begin
                p_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p_reg <= p_next;
        end
        if (out_load) begin
            m_reg      <= p_reg;
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_accepted = m_reg.accepted;
    assign m_item_out = m_item_reg;
    assign m_is_empty = m_reg.is_empty;
    assign m_is_full  = m_reg.is_full;
    assign m_count    = m_reg.count;

endmodule

// ===== design/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks on the ring buffer deque result channel.
// ----------------------------------------------------------------------------
module rbd_checker #(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32,
    localparam int CAP_W        = $clog2(DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_accepted,
    input  logic [ELEMENT_WIDTH-1:0] m_item_out,
    input  logic                     m_is_empty,
    input  logic                     m_is_full,
    input  logic [CAP_W-1:0]         m_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_out) && $stable(m_count)
            && $stable(m_accepted))
        else $error("result item changed while stalled");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_empty && m_is_full))
        else $error("empty and full both set");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_item_out == '0)
        else $error("rejected item carries data");

endmodule

bind ring_buffer_deque_top rbd_checker #(
    .DEPTH(DEPTH),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
) u_rbd_checker (.*);

// ===== test/ring_buffer_deque_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_top_test
// Self-checking bench for the ring buffer deque: push back, pop back, pop front.
// ----------------------------------------------------------------------------
// A queue of pending operations feeds a valid/ready driver. A shadow deque
// predicts every result at input acceptance, and the monitor compares each
// result item field by field, in order. Phases run under several capacities,
// including the out-of-range settings 0 and 511, with random idling on both
// sides, one stretch without idling and one long receiver hold that fills the
// block and stalls its input.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top_test;
    import rbd_pkg::*;

    localparam int DEPTH       = 256;
    localparam int ELEM_W      = 32;
    localparam int CAP_W       = 9;
    localparam int IDX_W       = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_PCT    = 29;
    localparam op_t OP_UNUSED  = 2'd3;

    typedef struct packed {
        op_t              op;
        logic [ELEM_W-1:0] value;
    } deque_cmd_t;

    typedef struct packed {
        logic              accepted;
        logic [ELEM_W-1:0] item_out;
        logic              is_empty;
        logic              is_full;
        logic [CAP_W-1:0]  count;
    } deque_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    op_t               s_op = OP_PUSH;
    logic [ELEM_W-1:0] s_item_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_accepted;
    logic [ELEM_W-1:0] m_item_out;
    logic              m_is_empty;
    logic              m_is_full;
    logic [CAP_W-1:0]  m_count;

    deque_cmd_t    op_backlog[$];
    deque_result_t predicted_results[$];
    deque_cmd_t    next_cmd;
    deque_result_t predicted;
    deque_result_t wanted;

    logic [ELEM_W-1:0] shadow_slots [DEPTH];
    int unsigned       shadow_front = 0;
    int unsigned       shadow_back = 0;
    int unsigned       shadow_count = 0;
    logic [CAP_W-1:0]  shadow_capacity = 9'd256;

    bit in_taken = 1'b0;
    bit cfg_taken = 1'b0;
    bit steady = 1'b0;
    bit choke_req = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int fault_count = 0;

    ring_buffer_deque_top #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEM_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_item_out   (m_item_out),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full),
        .m_count      (m_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_fault(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [ELEM_W-1:0] want,
                               input logic [ELEM_W-1:0] got);
        if (got !== want) begin
            report_fault($sformatf("%s expected %h got %h", name, want, got));
        end
    endtask

    // shadow deque: one operation, result after it
    task automatic predict_deque_op(input deque_cmd_t cmd, output deque_result_t res);
        int unsigned cap_now;
        cap_now = shadow_capacity;
        if (cap_now == 0) begin
            cap_now = 1;
        end else if (cap_now > DEPTH) begin
            cap_now = DEPTH;
        end
        res = '0;
        case (cmd.op)
            OP_PUSH: begin
                if (shadow_count < cap_now) begin
                    shadow_slots[shadow_back[IDX_W-1:0]] = cmd.value;
                    shadow_back = (shadow_back + 1 >= cap_now) ? 0 : shadow_back + 1;
                    shadow_count++;
                    res.accepted = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (shadow_count != 0) begin
                    shadow_back = (shadow_back == 0) ? cap_now - 1 : shadow_back - 1;
                    res.item_out = shadow_slots[shadow_back[IDX_W-1:0]];
                    shadow_count--;
                    res.accepted = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_count != 0) begin
                    res.item_out = shadow_slots[shadow_front[IDX_W-1:0]];
                    shadow_front = (shadow_front + 1 >= cap_now) ? 0 : shadow_front + 1;
                    shadow_count--;
                    res.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.is_empty = (shadow_count == 0);
        res.is_full  = (shadow_count >= cap_now);
        res.count    = shadow_count[CAP_W-1:0];
    endtask

    function automatic logic [ELEM_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t rand_op(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            return OP_UNUSED;
        end else if (r < 3 + push_pct) begin
            return OP_PUSH;
        end
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    task automatic add_cmd(input op_t op, input logic [ELEM_W-1:0] value);
        op_backlog.push_back('{op: op, value: value});
    endtask

    task automatic add_random(input int n, input int push_pct);
        for (int i = 0; i < n; i++) begin
            add_cmd(rand_op(push_pct), rand_word());
        end
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(negedge aclk);
        while (!cfg_taken) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (op_backlog.size() != 0 || s_valid || predicted_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (op_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_cmd = op_backlog.pop_front();
                s_valid      <= 1'b1;
                s_op         <= next_cmd.op;
                s_item_value <= next_cmd.value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (choke_req) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // prediction and result checking
    always @(posedge aclk) begin
        in_taken  <= s_valid && s_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                shadow_capacity = cfg_data;
                shadow_front = 0;
                shadow_back  = 0;
                shadow_count = 0;
            end
            if (s_valid && s_ready) begin
                predict_deque_op('{op: s_op, value: s_item_value}, predicted);
                predicted_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_fault("result item with nothing expected");
                end else begin
                    wanted = predicted_results.pop_front();
                    check_field("accepted", ELEM_W'(wanted.accepted), ELEM_W'(m_accepted));
                    check_field("item_out", wanted.item_out, m_item_out);
                    check_field("is_empty", ELEM_W'(wanted.is_empty), ELEM_W'(m_is_empty));
                    check_field("is_full", ELEM_W'(wanted.is_full), ELEM_W'(m_is_full));
                    check_field("count", ELEM_W'(wanted.count), ELEM_W'(m_count));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset capacity: empty rejects, unused op, extreme values
        add_cmd(OP_POP_FRONT, 32'h1234_5678);
        add_cmd(OP_POP_BACK, '1);
        add_cmd(OP_UNUSED, '1);
        add_cmd(OP_PUSH, '1);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_UNUSED, 32'hA5A5_5A5A);
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_POP_FRONT, '0);
        wait_drained();

        // two slots: full reject, front pop, back index wrap
        write_capacity(9'd2);
        add_cmd(OP_PUSH, 32'h0000_00A1);
        add_cmd(OP_PUSH, 32'h0000_00B2);
        add_cmd(OP_PUSH, 32'h0000_00C3);
        add_cmd(OP_POP_FRONT, '0);
        add_cmd(OP_PUSH, 32'h0000_00D4);
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_POP_BACK, '0);
        add_cmd(OP_POP_BACK, '0);
        wait_drained();

        // zero acts as one slot
        write_capacity(9'd0);
        add_random(30, 50);
        wait_drained();

        write_capacity(9'd1);
        add_random(20, 50);
        wait_drained();

        write_capacity(9'd3);
        add_random(60, 50);
        wait_drained();

        // above depth acts as full depth: fill past full under a long hold
        steady <= 1'b1;
        write_capacity(9'd511);
        for (int i = 0; i < 258; i++) begin
            add_cmd(OP_PUSH, rand_word());
        end
        add_random(12, 40);
        choke_req <= 1'b1;
        while (hold_left == 0) @(negedge aclk);
        choke_req <= 1'b0;
        wait_drained();
        steady <= 1'b0;

        // fill and drain bursts
        write_capacity(9'd7);
        for (int b = 0; b < 10; b++) begin
            add_random(10, (b % 2 == 0) ? 80 : 15);
        end
        wait_drained();

        write_capacity(9'd256);
        add_random(60, 55);
        wait_drained();

        repeat (8) @(negedge aclk);
        if (predicted_results.size() != 0) begin
            report_fault("expected result items never arrived");
        end
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
